// ===== rtl/tgasd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgasd_pkg
// shared types and constants for the truecolor tga stream decoder
// ----------------------------------------------------------------------------
package tgasd_pkg;

    // header layout
    localparam int HDR_IDX_W = 5;
    localparam logic [HDR_IDX_W-1:0] HDR_IDLEN_IDX    = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE_IDX     = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_LO_IDX = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_HI_IDX = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_LO_IDX = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_HI_IDX = 5'd15;
    localparam logic [HDR_IDX_W-1:0] HDR_DEPTH_IDX    = 5'd16;
    localparam logic [HDR_IDX_W-1:0] HDR_DESC_IDX     = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam int DESC_TOP_BIT   = 5;
    localparam int PKT_REPEAT_BIT = 7;

    // result status codes
    localparam logic [1:0] STATUS_RUN       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DEPTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;

    // result tdata layout
    localparam int OUT_DATA_W = 72;
    localparam int OUT_COUNT_LO = 32;
    localparam int OUT_COUNT_HI = 39;
    localparam logic [7:0] MAX_RUN = 8'd128;

    // serial divider for runs that cross several scanlines
    localparam int DIV_BITS  = 8;
    localparam int DIV_CNT_W = 3;

    typedef struct packed {
        logic                busy;
        logic                valid;
        logic [DIV_BITS-1:0] quot;
        logic [DIV_BITS-2:0] rem;
    } div_status_t;

endpackage

// ===== rtl/tga_truecolor_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder
// byte-wide tga parser and truecolor raw/rle pixel run decoder
// ----------------------------------------------------------------------------
// The decoder takes one file byte per cycle on the slave side and gives at
// most one result per byte on the master side: one per decoded pixel run,
// or one error for an unsupported depth or image type. A byte that may
// finish a result waits while the output register still holds an untaken
// result; other bytes keep flowing. A repeat run that passes more than one
// scanline boundary (only possible with images narrower than 128 pixels)
// starts the bit-serial divider that finds the new row and column; the byte
// that completes the next pixel then waits until the divider is through.
// The pixel count of the image comes from one registered 16x16 multiply
// made while the header is read.
module tga_truecolor_stream_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // data_byte
    input  logic [0:0]                           s_tuser,   // frame_start
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // run_row[15:0], run_col[31:16], run_count[39:32], blue[47:40],
    // green[55:48], red[63:56], alpha[71:64]
    output logic [tgasd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,   // frame_end
    output logic [1:0]                           m_tuser    // status
);
    import tgasd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic                   m_valid_reg, m_valid_next;

    logic [7:0]             id_skip_reg, id_skip_next;
    logic [15:0]            width_reg, width_next;
    logic [15:0]            height_reg, height_next;
    logic                   four_reg, four_next;
    logic                   rle_reg, rle_next;
    logic                   top_reg, top_next;
    logic                   type_ok_reg, type_ok_next;
    logic [15:0]            row_reg, row_next;
    logic [15:0]            col_reg, col_next;
    logic [7:0]             pkt_left_reg, pkt_left_next;
    logic                   repeat_reg, repeat_next;
    logic [1:0]             pix_idx_reg, pix_idx_next;
    logic [7:0]             pix0_reg, pix0_next;
    logic [7:0]             pix1_reg, pix1_next;
    logic [7:0]             pix2_reg, pix2_next;
    logic [31:0]            total_reg;
    logic [31:0]            remain_reg, remain_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic [1:0]             out_status_reg, out_status_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   may_result;
    logic                   div_block;
    logic [1:0]             last_idx;
    logic [7:0]             b;
    phase_t                 eff_phase;
    logic [HDR_IDX_W-1:0]   eff_idx;

    logic [7:0]             want;
    logic                   run_done;
    logic [7:0]             placed;
    logic [16:0]            col_sum;
    logic [16:0]            col_wrap;
    logic                   past_one;
    logic                   past_two;
    logic [7:0]             red_val;
    logic [7:0]             alpha_val;

    logic                   div_start;
    div_status_t            div_st;

    tgasd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (col_sum[DIV_BITS-1:0]),
        .divisor  (width_reg[DIV_BITS-2:0]),
        .status   (div_st)
    );

    assign b         = s_tdata;
    assign last_idx  = four_reg ? 2'd3 : 2'd2;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign may_result = ((phase_reg == PH_HEADER) &&
                         ((hdr_idx_reg == HDR_DEPTH_IDX) || (hdr_idx_reg == HDR_DESC_IDX))) ||
                        ((phase_reg == PH_PIXEL) && (pix_idx_reg == last_idx));
    // the next pixel needs the position the divider is still working out
    assign div_block  = (phase_reg == PH_PIXEL) && (pix_idx_reg == last_idx) &&
                        (div_st.busy || div_st.valid);
    assign s_tready   = !div_block && (out_free || !may_result);

    // frame start restarts the header parse with this byte
    assign eff_phase = s_tuser[0] ? PH_HEADER : phase_reg;
    assign eff_idx   = s_tuser[0] ? HDR_IDLEN_IDX : hdr_idx_reg;

    // run placement
    assign want     = (rle_reg && repeat_reg) ? pkt_left_reg : 8'd1;
    assign run_done = remain_reg <= {24'b0, want};
    assign placed   = run_done ? remain_reg[7:0] : want;
    assign col_sum  = {1'b0, col_reg} + {9'b0, want};
    assign col_wrap = col_sum - {1'b0, width_reg};
    assign past_one = col_sum >= {1'b0, width_reg};
    assign past_two = col_sum >= {width_reg, 1'b0};
    assign red_val  = four_reg ? pix2_reg : b;
    assign alpha_val = four_reg ? b : 8'd0;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        id_skip_next    = id_skip_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        four_next       = four_reg;
        rle_next        = rle_reg;
        top_next        = top_reg;
        type_ok_next    = type_ok_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pkt_left_next   = pkt_left_reg;
        repeat_next     = repeat_reg;
        pix_idx_next    = pix_idx_reg;
        pix0_next       = pix0_reg;
        pix1_next       = pix1_reg;
        pix2_next       = pix2_reg;
        remain_next     = remain_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        div_start       = 1'b0;

        if (div_st.valid)
        begin
            col_next = {9'b0, div_st.rem};
            row_next = top_reg ? row_reg + {8'b0, div_st.quot}
                               : row_reg - {8'b0, div_st.quot};
        end

        if (in_accept)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    phase_next   = PH_HEADER;
                    hdr_idx_next = eff_idx + 1'b1;
                    case (eff_idx)
                        HDR_IDLEN_IDX:     id_skip_next = b;
                        HDR_TYPE_IDX:
                        begin
                            rle_next     = (b == TYPE_RLE);
                            type_ok_next = (b == TYPE_RAW) || (b == TYPE_RLE);
                        end
                        HDR_WIDTH_LO_IDX:  width_next[7:0]   = b;
                        HDR_WIDTH_HI_IDX:  width_next[15:8]  = b;
                        HDR_HEIGHT_LO_IDX: height_next[7:0]  = b;
                        HDR_HEIGHT_HI_IDX: height_next[15:8] = b;
                        HDR_DEPTH_IDX:
                        begin
                            if ((b != DEPTH_24) && (b != DEPTH_32))
                            begin
                                phase_next      = PH_DONE;
                                m_valid_next    = 1'b1;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                                out_status_next = STATUS_BAD_DEPTH;
                            end
                            else
                            begin
                                four_next = (b == DEPTH_32);
                            end
                        end
                        HDR_DESC_IDX:
                        begin
                            top_next = b[DESC_TOP_BIT];
                            if (!type_ok_reg)
                            begin
                                phase_next      = PH_DONE;
                                m_valid_next    = 1'b1;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                                out_status_next = STATUS_BAD_TYPE;
                            end
                            else if ((width_reg == 16'd0) || (height_reg == 16'd0))
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                remain_next = total_reg;
                                if (id_skip_reg != 8'd0)
                                begin
                                    phase_next = PH_IDSKIP;
                                end
                                else
                                begin
                                    col_next      = 16'd0;
                                    row_next      = b[DESC_TOP_BIT] ? 16'd0
                                                                    : height_reg - 16'd1;
                                    pix_idx_next  = 2'd0;
                                    pkt_left_next = 8'd0;
                                    repeat_next   = 1'b0;
                                    phase_next    = rle_reg ? PH_PACKET : PH_PIXEL;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                PH_IDSKIP:
                begin
                    id_skip_next = id_skip_reg - 8'd1;
                    if (id_skip_reg == 8'd1)
                    begin
                        col_next      = 16'd0;
                        row_next      = top_reg ? 16'd0 : height_reg - 16'd1;
                        pix_idx_next  = 2'd0;
                        pkt_left_next = 8'd0;
                        repeat_next   = 1'b0;
                        phase_next    = rle_reg ? PH_PACKET : PH_PIXEL;
                    end
                end

                PH_PACKET:
                begin
                    pkt_left_next = {1'b0, b[PKT_REPEAT_BIT-1:0]} + 8'd1;
                    repeat_next   = b[PKT_REPEAT_BIT];
                    pix_idx_next  = 2'd0;
                    phase_next    = PH_PIXEL;
                end

                PH_PIXEL:
                begin
                    if (pix_idx_reg != last_idx)
                    begin
                        pix_idx_next = pix_idx_reg + 2'd1;
                        case (pix_idx_reg)
                            2'd0:    pix0_next = b;
                            2'd1:    pix1_next = b;
                            default: pix2_next = b;
                        endcase
                    end
                    else
                    begin
                        pix_idx_next    = 2'd0;
                        m_valid_next    = 1'b1;
                        out_data_next   = {alpha_val, red_val, pix1_reg, pix0_reg,
                                           placed, col_reg, row_reg};
                        out_last_next   = run_done;
                        out_status_next = STATUS_RUN;
                        if (run_done)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            remain_next = remain_reg - {24'b0, want};
                            if (!past_one)
                            begin
                                col_next = col_sum[15:0];
                            end
                            else if (!past_two)
                            begin
                                col_next = col_wrap[15:0];
                                row_next = top_reg ? row_reg + 16'd1 : row_reg - 16'd1;
                            end
                            else
                            begin
                                div_start = 1'b1;
                            end
                            if (rle_reg)
                            begin
                                if (repeat_reg)
                                begin
                                    pkt_left_next = 8'd0;
                                    phase_next    = PH_PACKET;
                                end
                                else
                                begin
                                    pkt_left_next = pkt_left_reg - 8'd1;
                                    if (pkt_left_reg == 8'd1)
                                    begin
                                        phase_next = PH_PACKET;
                                    end
                                end
                            end
                        end
                    end
                end

                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_skip_reg    <= id_skip_next;
        width_reg      <= width_next;
        height_reg     <= height_next;
        four_reg       <= four_next;
        rle_reg        <= rle_next;
        top_reg        <= top_next;
        type_ok_reg    <= type_ok_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        pkt_left_reg   <= pkt_left_next;
        repeat_reg     <= repeat_next;
        pix_idx_reg    <= pix_idx_next;
        pix0_reg       <= pix0_next;
        pix1_reg       <= pix1_next;
        pix2_reg       <= pix2_next;
        // image size, registered from the width and height, is ready by the descriptor byte
        total_reg      <= width_reg * height_reg;
        remain_reg     <= remain_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/tgasd_div.sv =====
// ----------------------------------------------------------------------------
// tgasd_div
// restoring divider, one quotient bit per cycle, for scanline wrap of runs
// ----------------------------------------------------------------------------
module tgasd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tgasd_pkg::DIV_BITS-1:0]      dividend,
    input  logic [tgasd_pkg::DIV_BITS-2:0]      divisor,
    output tgasd_pkg::div_status_t              status
);
    import tgasd_pkg::*;

    logic                 busy_reg;
    logic                 valid_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_BITS-1:0]  dvd_reg;
    logic [DIV_BITS-2:0]  dvs_reg;
    logic [DIV_BITS-2:0]  rem_reg;
    logic [DIV_BITS-1:0]  quot_reg;

    logic [DIV_BITS-1:0]  trial;
    logic [DIV_BITS-1:0]  diff;
    logic                 fits;
    logic [DIV_BITS-2:0]  rem_step;

    assign trial    = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    // partial remainder stays below the divisor, so the top bit is always clear
    assign rem_step = fits ? diff[DIV_BITS-2:0] : trial[DIV_BITS-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
            begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
        else
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[DIV_BITS-2:0], 1'b0};
            rem_reg  <= rem_step;
            quot_reg <= {quot_reg[DIV_BITS-2:0], fits};
        end
    end

    assign status.busy  = busy_reg;
    assign status.valid = valid_reg;
    assign status.quot  = quot_reg;
    assign status.rem   = rem_reg;

endmodule

// ===== rtl/tgasd_checker.sv =====
// ----------------------------------------------------------------------------
// tgasd_checker
// port-level checks on the result stream of the tga stream decoder
// ----------------------------------------------------------------------------
module tgasd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tgasd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                             m_tlast,
    input logic [1:0]                       m_tuser
);
    import tgasd_pkg::*;

    logic [7:0] count;
    assign count = m_tdata[OUT_COUNT_HI:OUT_COUNT_LO];

    // a stalled transaction keeps its whole payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser))
        else $error("result changed while stalled");

    // error results carry no pixels and close the frame
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_RUN) |-> m_tlast && (m_tdata == '0))
        else $error("malformed error result");

    // pixel runs hold between one and a full packet of pixels
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_RUN) |-> (count != 8'd0) && (count <= MAX_RUN))
        else $error("run count out of range");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_RUN) || (m_tuser == STATUS_BAD_DEPTH)
                     || (m_tuser == STATUS_BAD_TYPE))
        else $error("unknown status code");

    // a byte taken outside frame start while a result is stalled keeps that result valid
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] && !m_tready && m_tvalid
        |=> m_tvalid)
        else $error("pending result lost");

endmodule

bind tga_truecolor_stream_decoder tgasd_checker u_tgasd_checker (.*);
